// ===== hdl/rrds_pkg.sv =====
// ----------------------------------------------------------------------------
// rrds_pkg
// Shared types and constants of the round-robin delay scheduler.
// ----------------------------------------------------------------------------
package rrds_pkg;

  localparam int unsigned TaskCountW = 4;
  localparam int unsigned MsPerTickW = 10;
  localparam int unsigned CfgDataW   = 10;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned ModeW      = 2;
  localparam int unsigned DelayW     = 16;
  localparam int unsigned NextTaskW  = 3;
  localparam int unsigned TickW      = 32;
  localparam int unsigned ElapsedW   = 32;

  localparam logic [CfgIdxW-1:0] RegTaskCount = 1'b0;
  localparam logic [CfgIdxW-1:0] RegMsPerTick = 1'b1;

  typedef enum logic [ModeW-1:0] {
    MODE_TICK  = 2'd0,
    MODE_DELAY = 2'd1,
    MODE_YIELD = 2'd2
  } mode_e;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_LOAD = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  typedef struct packed {
    logic accept;
    logic scan;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic hit;
  } status_t;

endpackage

// ===== hdl/rrds_ctrl.sv =====
// ----------------------------------------------------------------------------
// rrds_ctrl
// Sequencer: takes a word, runs the slot scan, loads and strobes the result.
// ----------------------------------------------------------------------------
module rrds_ctrl
  import rrds_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  output logic    valid_o,
  output cmd_t    cmd_o,
  input  status_t status_i
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.accept = 1'b1;
          state_d      = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.hit) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy    = (state_q != S_IDLE);
  assign valid_o = (state_q == S_DONE);

endmodule

// ===== hdl/rrds_datapath.sv =====
// ----------------------------------------------------------------------------
// rrds_datapath
// Slot delays, tick counter, config registers, scan pointer and result regs.
// ----------------------------------------------------------------------------
module rrds_datapath
  import rrds_pkg::*;
#(
  parameter int unsigned MAX_TASKS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_idx_i,
  input  logic [CfgDataW-1:0]   cfg_data_i,
  input  logic [ModeW-1:0]      mode_i,
  input  logic [DelayW-1:0]     delay_ticks_i,
  input  cmd_t                  cmd_i,
  output status_t               status_o,
  output logic [NextTaskW-1:0]  next_task_o,
  output logic [TickW-1:0]      tick_count_o,
  output logic [ElapsedW-1:0]   elapsed_ms_o
);

  localparam int unsigned IdxW = $clog2(MAX_TASKS);
  localparam int unsigned CntW = $clog2(MAX_TASKS + 1);
  localparam int unsigned NW   = (CntW > TaskCountW) ? CntW : TaskCountW;
  localparam int unsigned CW   = NW + 1;
  localparam int unsigned ProdW = TickW + MsPerTickW;

  logic [TaskCountW-1:0] task_count_q;
  logic [MsPerTickW-1:0] ms_per_tick_q;
  logic [DelayW-1:0]     delay_q [MAX_TASKS];
  logic [IdxW-1:0]       cur_q;
  logic [IdxW-1:0]       idx_q;
  logic [TickW-1:0]      tick_q;

  logic [CW-1:0]         n;
  logic [CW-1:0]         inc;
  logic [IdxW-1:0]       idx_nxt;
  logic                  hit;
  logic [ProdW-1:0]      prod;
  logic [IdxW+2:0]       cur_ext;

  // live slot count, clamped to one..MAX_TASKS
  always_comb begin
    if (task_count_q == '0) begin
      n = CW'(1);
    end else if (CW'(task_count_q) > CW'(MAX_TASKS)) begin
      n = CW'(MAX_TASKS);
    end else begin
      n = CW'(task_count_q);
    end
  end

  // one step of the round-robin scan
  always_comb begin
    inc = CW'(idx_q) + CW'(1);
    if (inc >= n) begin
      idx_nxt = '0;
    end else begin
      idx_nxt = IdxW'(inc);
    end
    hit = (idx_nxt == '0) || (delay_q[idx_nxt] == '0);
  end

  assign status_o.hit = hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      task_count_q  <= TaskCountW'(1);
      ms_per_tick_q <= MsPerTickW'(1);
      cur_q         <= '0;
      tick_q        <= '0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        delay_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegTaskCount: task_count_q  <= cfg_data_i[TaskCountW-1:0];
          RegMsPerTick: ms_per_tick_q <= cfg_data_i[MsPerTickW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.accept) begin
        case (mode_i)
          MODE_TICK: begin
            tick_q <= tick_q + TickW'(1);
            for (int i = 1; i < MAX_TASKS; i++) begin
              if ((CW'(i) < n) && (delay_q[i] != '0)) begin
                delay_q[i] <= delay_q[i] - DelayW'(1);
              end
            end
          end
          MODE_DELAY: begin
            if (cur_q != '0) begin
              delay_q[cur_q] <= delay_ticks_i;
            end
          end
          default: ;
        endcase
      end
      if (cmd_i.scan && hit) begin
        cur_q <= idx_nxt;
      end
    end
  end

  assign prod    = ProdW'(tick_q) * ProdW'(ms_per_tick_q);
  assign cur_ext = (IdxW + 3)'(cur_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      idx_q <= cur_q;
    end else if (cmd_i.scan) begin
      idx_q <= idx_nxt;
    end
    if (cmd_i.load) begin
      next_task_o  <= cur_ext[NextTaskW-1:0];
      tick_count_o <= tick_q;
      elapsed_ms_o <= prod[ElapsedW-1:0];
    end
  end

endmodule

// ===== hdl/round_robin_delay_scheduler.sv =====
// ----------------------------------------------------------------------------
// round_robin_delay_scheduler
// Round-robin task scheduler with per-slot tick delays and elapsed time.
// ----------------------------------------------------------------------------
// usage:
//   input word: mode_i and delay_ticks_i, taken on a clock edge with start
//   high and busy low. mode tick bumps the tick counter and counts down the
//   delays of the live slots; mode delay blocks the current slot (ignored
//   for the idle slot); yield, and the unused code, only reschedule.
//   config: cfg_we_i with cfg_idx_i 0 (task_count) or 1 (ms_per_tick),
//   written at once; writing only while busy is low is left to the user.
//   result word: next_task_o, tick_count_o and elapsed_ms_o, shown for one
//   cycle with valid_o high; the receiver cannot stall it.
//   sequence: the scan visits one slot a cycle, one to n steps, n the live
//   slot count; the load state then registers the result and its multiply,
//   and valid_o rises in the done state. busy stays high through it, so a
//   new word is only taken once the last result has been shown.
//   reset: all delays clear, the idle slot is current, tick count is zero,
//   task_count and ms_per_tick read one.
// ----------------------------------------------------------------------------
module round_robin_delay_scheduler
  import rrds_pkg::*;
#(
  parameter int unsigned MAX_TASKS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_idx_i,
  input  logic [CfgDataW-1:0]   cfg_data_i,
  input  logic                  start,
  output logic                  busy,
  input  logic [ModeW-1:0]      mode_i,
  input  logic [DelayW-1:0]     delay_ticks_i,
  output logic                  valid_o,
  output logic [NextTaskW-1:0]  next_task_o,
  output logic [TickW-1:0]      tick_count_o,
  output logic [ElapsedW-1:0]   elapsed_ms_o
);

  cmd_t    cmd;
  status_t status;

  rrds_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .valid_o  (valid_o),
    .cmd_o    (cmd),
    .status_i (status)
  );

  rrds_datapath #(
    .MAX_TASKS (MAX_TASKS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .mode_i        (mode_i),
    .delay_ticks_i (delay_ticks_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .next_task_o   (next_task_o),
    .tick_count_o  (tick_count_o),
    .elapsed_ms_o  (elapsed_ms_o)
  );

endmodule

// ===== hdl/rrds_checker.sv =====
// ----------------------------------------------------------------------------
// rrds_checker
// Port-level checks of the scheduler handshake and result strobe.
// ----------------------------------------------------------------------------
module rrds_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic valid_o
);

  // a taken word keeps the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // no result straight after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> !valid_o)
    else $error("result too early after accept");

  // a result is only shown while the word is still owned
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy)
    else $error("result strobe while idle");

  // one strobe per word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> (!valid_o && !busy))
    else $error("result strobe repeated");

endmodule

bind round_robin_delay_scheduler rrds_checker u_rrds_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start   (start),
  .busy    (busy),
  .valid_o (valid_o)
);

// ===== sim/tb_round_robin_delay_scheduler.sv =====
// ----------------------------------------------------------------------------
// tb_round_robin_delay_scheduler
// Self-checking bench for the round-robin delay scheduler. Event words go in
// through the start/busy handshake, and an in-bench scheduler model predicts
// the next task, tick count and elapsed time of every result word. Directed
// cases cover the reset settings, delay loads, the idle slot and the limits
// of the task count. Random phases then run under varied settings, with
// bursty traffic.
// ----------------------------------------------------------------------------
module tb_round_robin_delay_scheduler
  import rrds_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxTasks = 8;
  localparam logic [ModeW-1:0] ModeSpare = 2'd3;

  typedef struct {
    logic [NextTaskW-1:0] next_task;
    logic [TickW-1:0]     tick_count;
    logic [ElapsedW-1:0]  elapsed_ms;
  } sched_result_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i     = RegTaskCount;
  logic [CfgDataW-1:0]  cfg_data_i    = '0;
  logic                 start         = 1'b0;
  logic                 busy;
  logic [ModeW-1:0]     mode_i        = MODE_YIELD;
  logic [DelayW-1:0]    delay_ticks_i = '0;
  logic                 valid_o;
  logic [NextTaskW-1:0] next_task_o;
  logic [TickW-1:0]     tick_count_o;
  logic [ElapsedW-1:0]  elapsed_ms_o;

  // scheduler model state
  logic [DelayW-1:0]     slot_delay [MaxTasks] = '{default: '0};
  logic [NextTaskW-1:0]  cur_slot   = '0;
  logic [TickW-1:0]      tick_total = '0;
  logic [TaskCountW-1:0] slot_limit = 4'd1;
  logic [MsPerTickW-1:0] ms_tick    = 10'd1;

  sched_result_t expected_sched_q [$];
  sched_result_t due_word;
  int            error_count = 0;

  round_robin_delay_scheduler #(
    .MAX_TASKS(MaxTasks)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .start        (start),
    .busy         (busy),
    .mode_i       (mode_i),
    .delay_ticks_i(delay_ticks_i),
    .valid_o      (valid_o),
    .next_task_o  (next_task_o),
    .tick_count_o (tick_count_o),
    .elapsed_ms_o (elapsed_ms_o)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

  function automatic void flag_error(string msg);
    if (error_count < 10) begin
      $display("%s", msg);
    end
    error_count++;
  endfunction

  function automatic sched_result_t schedule_event(logic [ModeW-1:0] m, logic [DelayW-1:0] d);
    int            live;
    int            idx;
    sched_result_t r;
    live = (slot_limit == 0) ? 1 : (slot_limit > MaxTasks) ? MaxTasks : int'(slot_limit);
    case (m)
      MODE_TICK: begin
        tick_total++;
        for (int i = 1; i < live; i++) begin
          if (slot_delay[i] != 0) slot_delay[i]--;
        end
      end
      MODE_DELAY: begin
        if (cur_slot != 0) slot_delay[cur_slot] = d;
      end
      default: ;
    endcase
    // scan forward from the slot after the current one; slot 0 always ready
    idx = int'(cur_slot);
    for (int k = 0; k < live; k++) begin
      idx++;
      if (idx >= live) idx = 0;
      if (idx == 0 || slot_delay[idx] == 0) break;
    end
    cur_slot     = idx[NextTaskW-1:0];
    r.next_task  = cur_slot;
    r.tick_count = tick_total;
    r.elapsed_ms = tick_total * TickW'(ms_tick);
    return r;
  endfunction

  task automatic send_word(input logic [ModeW-1:0] m, input logic [DelayW-1:0] d);
    start         <= 1'b1;
    mode_i        <= m;
    delay_ticks_i <= d;
    do @(posedge clk_i); while (busy !== 1'b0);
    expected_sched_q.push_back(schedule_event(m, d));
  endtask

  task automatic quiesce();
    start <= 1'b0;
    do @(posedge clk_i); while (expected_sched_q.size() != 0 || busy !== 1'b0);
    repeat (MaxTasks + 3) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [CfgDataW-1:0] count_word,
                            input logic [CfgDataW-1:0] ms_word);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= RegTaskCount;
    cfg_data_i <= count_word;
    @(posedge clk_i);
    slot_limit = count_word[TaskCountW-1:0];
    cfg_idx_i  <= RegMsPerTick;
    cfg_data_i <= ms_word;
    @(posedge clk_i);
    ms_tick = ms_word[MsPerTickW-1:0];
    cfg_we_i <= 1'b0;
  endtask

  // single idle slot, settings as after reset
  task automatic test_reset_defaults();
    send_word(MODE_TICK, 16'h0000);
    send_word(MODE_DELAY, 16'hFFFF);
    send_word(MODE_YIELD, 16'h5A5A);
    send_word(ModeSpare, 16'hA5A5);
  endtask

  task automatic test_delay_requests();
    quiesce();
    set_config(10'd8, 10'd1000);
    while (cur_slot != 7) send_word(MODE_YIELD, 16'($urandom));
    send_word(MODE_DELAY, 16'hFFFF);
    send_word(MODE_YIELD, 16'h0000);
    send_word(MODE_DELAY, 16'd1);
    // zero delay keeps the slot ready but the scan still moves on
    send_word(MODE_DELAY, 16'd0);
    send_word(MODE_TICK, 16'hFFFF);
    send_word(MODE_YIELD, 16'h0000);
  endtask

  task automatic test_count_limits();
    quiesce();
    set_config(10'd0, 10'd0);
    send_word(MODE_TICK, 16'h1234);
    send_word(MODE_DELAY, 16'd5);
    quiesce();
    set_config({6'h3F, 4'hF}, 10'd1023);
    send_word(MODE_TICK, 16'h0000);
    send_word(MODE_DELAY, 16'd3);
    while (cur_slot < 3) send_word(MODE_YIELD, 16'h0000);
    // shrink the count below the current slot
    quiesce();
    set_config(10'd2, 10'd1);
    send_word(MODE_YIELD, 16'h0000);
    send_word(ModeSpare, 16'hFFFF);
  endtask

  task automatic test_random_traffic();
    logic [CfgDataW-1:0] count_word;
    logic [CfgDataW-1:0] ms_word;
    logic [ModeW-1:0]    m;
    logic [DelayW-1:0]   d;
    int                  r;
    int                  burst_left;
    for (int phase = 0; phase < 8; phase++) begin
      quiesce();
      case (phase)
        0: begin
          count_word = 10'd8;
          ms_word    = 10'd1000;
        end
        1: begin
          count_word = 10'd1;
          ms_word    = 10'd1;
        end
        2: begin
          count_word = 10'd0;
          ms_word    = 10'd0;
        end
        3: begin
          count_word = {6'($urandom), 4'hF};
          ms_word    = 10'd1023;
        end
        6: begin
          count_word = 10'($urandom);
          ms_word    = 10'($urandom);
        end
        default: begin
          count_word = 10'($urandom_range(2, 8));
          ms_word    = 10'($urandom);
        end
      endcase
      set_config(count_word, ms_word);
      burst_left = $urandom_range(1, 30);
      for (int n = 0; n < 240; n++) begin
        r = $urandom_range(0, 9);
        m = (r < 4) ? MODE_TICK : (r < 7) ? MODE_DELAY : (r < 9) ? MODE_YIELD : ModeSpare;
        d = 16'($urandom);
        if (m == MODE_DELAY) begin
          // mostly short delays so that blocked slots come back
          r = $urandom_range(0, 299);
          if (r < 270) d = 16'($urandom_range(0, 8));
          else if (r < 297) d = 16'($urandom_range(0, 40));
          else if (r == 297) d = 16'h0000;
          else if (r == 298) d = 16'hFFFF;
        end
        send_word(m, d);
        burst_left--;
        if (burst_left == 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 12)) @(posedge clk_i);
          burst_left = $urandom_range(1, 30);
        end
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (valid_o === 1'b1) begin
      if (expected_sched_q.size() == 0) begin
        flag_error($sformatf("unexpected result word: task %0d ticks %0d ms %0d",
                             next_task_o, tick_count_o, elapsed_ms_o));
      end else begin
        due_word = expected_sched_q.pop_front();
        if (next_task_o !== due_word.next_task) begin
          flag_error($sformatf("next_task: expected %0d, got %0d",
                               due_word.next_task, next_task_o));
        end
        if (tick_count_o !== due_word.tick_count) begin
          flag_error($sformatf("tick_count: expected %0d, got %0d",
                               due_word.tick_count, tick_count_o));
        end
        if (elapsed_ms_o !== due_word.elapsed_ms) begin
          flag_error($sformatf("elapsed_ms: expected %0d, got %0d",
                               due_word.elapsed_ms, elapsed_ms_o));
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_delay_requests();
    test_count_limits();
    test_random_traffic();
    quiesce();
    if (expected_sched_q.size() != 0) begin
      flag_error($sformatf("%0d result words never arrived", expected_sched_q.size()));
    end
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
